// File: hdl/aoc_pkg.sv
// Package for the ARGB source-over compositor.
// Holds the shared types, sizing constants and the divide-by-255 helper.
// No dependencies.
`default_nettype none

package aoc_pkg;

    localparam logic [7:0] CH_MAX     = 8'd255;
    localparam logic [15:0] ROUND_HALF = 16'd127;
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 8;
    localparam int ALPHA_LSB  = 24;
    localparam int Q_DEPTH    = 4;
    localparam int Q_IDX_W    = 2;
    localparam int OUT_DEPTH  = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int DIV_STAGES = 8;

    typedef enum logic [1:0] {
        CLS_DST,
        CLS_SRC,
        CLS_BLEND
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] dst;
        logic [31:0] src;
        logic [15:0] aprod;
    } work_t;

    typedef struct packed {
        logic  push;
        work_t item;
    } qwr_t;

    // Exact floor(x / 255) for x below 255 * 2**16, by shifts and one correction.
    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [25:0] acc;
        logic [15:0] q0;
        logic [25:0] r;
        acc = {2'b00, x} + {10'd0, x[23:8]} + {18'd0, x[23:16]};
        q0 = acc[23:8];
        r = {2'b00, x} - ({10'd0, q0} << 8) + {10'd0, q0};
        div255 = (r >= 26'd255) ? (q0 + 16'd1) : q0;
    endfunction

endpackage

`default_nettype wire

// File: hdl/aoc_front.sv
// Front end of the compositor: accepts pixel pairs and classifies them.
// Computes the destination alpha product and writes work items to the queue.
// Depends on aoc_pkg.
`default_nettype none

module aoc_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [31:0]   destination_pixel,
    input  wire logic [31:0]   source_pixel,
    input  wire logic          q_full,
    output aoc_pkg::qwr_t      q_wr
);

    logic          f_valid_reg;
    logic          f_valid_next;
    aoc_pkg::work_t f_item_reg;
    aoc_pkg::work_t item_next;
    logic [7:0]    sa;
    logic [7:0]    da;
    logic [7:0]    ia;
    logic          accept;
    logic          drain;

    assign sa = source_pixel[aoc_pkg::ALPHA_LSB +: aoc_pkg::CH_W];
    assign da = destination_pixel[aoc_pkg::ALPHA_LSB +: aoc_pkg::CH_W];
    assign ia = aoc_pkg::CH_MAX - sa;

    always_comb
    begin
        item_next.dst   = destination_pixel;
        item_next.src   = source_pixel;
        item_next.aprod = {8'd0, da} * {8'd0, ia};
        if (sa == 8'd0)
        begin
            item_next.cls = aoc_pkg::CLS_DST;
        end
        else if (sa == aoc_pkg::CH_MAX || da == 8'd0)
        begin
            item_next.cls = aoc_pkg::CLS_SRC;
        end
        else
        begin
            item_next.cls = aoc_pkg::CLS_BLEND;
        end
    end

    assign full   = f_valid_reg && q_full;
    assign accept = push && !full;
    assign drain  = f_valid_reg && !q_full;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (drain)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg <= item_next;
        end
    end

    assign q_wr.push = drain;
    assign q_wr.item = f_item_reg;

endmodule

`default_nettype wire

// File: hdl/aoc_queue.sv
// Short work queue between the front and back ends of the compositor.
// Four entries of classified work items with first-word fall-through reads.
// Depends on aoc_pkg.
`default_nettype none

module aoc_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire aoc_pkg::qwr_t  q_wr,
    output logic                q_full,
    input  wire logic           q_pop,
    output logic                q_empty,
    output aoc_pkg::work_t      q_item
);

    aoc_pkg::work_t                 mem_reg [aoc_pkg::Q_DEPTH];
    logic [aoc_pkg::Q_IDX_W:0]      wr_ptr_reg;
    logic [aoc_pkg::Q_IDX_W:0]      rd_ptr_reg;

    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (wr_ptr_reg[aoc_pkg::Q_IDX_W] != rd_ptr_reg[aoc_pkg::Q_IDX_W])
                  && (wr_ptr_reg[aoc_pkg::Q_IDX_W-1:0] == rd_ptr_reg[aoc_pkg::Q_IDX_W-1:0]);
    assign q_item  = mem_reg[rd_ptr_reg[aoc_pkg::Q_IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (q_wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg[aoc_pkg::Q_IDX_W-1:0]] <= q_wr.item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/aoc_divider.sv
// Pipelined restoring divider for one color channel, one quotient bit per stage.
// Quotients of 256 or more saturate to 255. Depends on aoc_pkg.
`default_nettype none

module aoc_divider
(
    input  wire logic        clk,
    input  wire logic [16:0] n,
    input  wire logic [7:0]  oa,
    output logic [7:0]       q
);

    logic [16:0] rem_reg [aoc_pkg::DIV_STAGES];
    logic [7:0]  quo_reg [aoc_pkg::DIV_STAGES];
    logic [7:0]  oa_reg  [aoc_pkg::DIV_STAGES];
    logic        sat_reg [aoc_pkg::DIV_STAGES];

    for (genvar i = 0; i < aoc_pkg::DIV_STAGES; i++)
    begin : g_stage
        localparam int K = aoc_pkg::DIV_STAGES - 1 - i;
        logic [16:0] rem_in;
        logic [7:0]  quo_in;
        logic [7:0]  oa_in;
        logic        sat_in;
        logic [16:0] dvs;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign rem_in = n;
            assign quo_in = 8'd0;
            assign oa_in  = oa;
            assign sat_in = (n[16:8] >= {1'b0, oa});
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign oa_in  = oa_reg[i-1];
            assign sat_in = sat_reg[i-1];
        end

        assign dvs = {9'd0, oa_in} << K;
        assign ge  = (rem_in >= dvs);

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? (rem_in - dvs) : rem_in;
            quo_reg[i] <= quo_in | (ge ? (8'd1 << K) : 8'd0);
            oa_reg[i]  <= oa_in;
            sat_reg[i] <= sat_in;
        end
    end

    assign q = sat_reg[aoc_pkg::DIV_STAGES-1] ? aoc_pkg::CH_MAX
                                              : quo_reg[aoc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/aoc_back.sv
// Back end of the compositor: blend arithmetic pipeline and result buffer.
// Issues work items on credit so the result buffer never overflows.
// Depends on aoc_pkg and aoc_divider.
`default_nettype none

module aoc_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire aoc_pkg::work_t  q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic [31:0]          composite_pixel
);

    localparam int LAST = aoc_pkg::DIV_STAGES - 1;

    logic                           issue;
    logic                           take;
    logic [aoc_pkg::OUT_IDX_W:0]    used_reg;
    logic [aoc_pkg::OUT_IDX_W:0]    used_next;

    logic        s1_valid_reg;
    logic        s1_bypass_reg;
    logic [31:0] s1_pix_reg;
    logic [7:0]  s1_oa_reg;
    logic [23:0] s1_t_reg [aoc_pkg::NUM_CH];
    logic [15:0] s1_s_reg [aoc_pkg::NUM_CH];
    logic [7:0]  s1_oa_next;
    logic [23:0] s1_t_next [aoc_pkg::NUM_CH];
    logic [15:0] s1_s_next [aoc_pkg::NUM_CH];

    logic        s2_valid_reg;
    logic        s2_bypass_reg;
    logic [31:0] s2_pix_reg;
    logic [7:0]  s2_oa_reg;
    logic [16:0] s2_n_reg [aoc_pkg::NUM_CH];
    logic [16:0] s2_n_next [aoc_pkg::NUM_CH];

    logic        ln_valid_reg  [aoc_pkg::DIV_STAGES];
    logic        ln_bypass_reg [aoc_pkg::DIV_STAGES];
    logic [31:0] ln_pix_reg    [aoc_pkg::DIV_STAGES];
    logic [7:0]  ln_oa_reg     [aoc_pkg::DIV_STAGES];

    logic [7:0]  quo [aoc_pkg::NUM_CH];
    logic [31:0] result;

    logic [31:0]                 mem_reg [aoc_pkg::OUT_DEPTH];
    logic [aoc_pkg::OUT_IDX_W:0] wr_ptr_reg;
    logic [aoc_pkg::OUT_IDX_W:0] rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign take  = pop && !empty;
    assign issue = !q_empty && (used_reg < (aoc_pkg::OUT_IDX_W + 1)'(aoc_pkg::OUT_DEPTH));
    assign q_pop = issue;

    always_comb
    begin
        used_next = used_reg;
        if (issue && !take)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (!issue && take)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_comb
    begin
        logic [7:0]  sa;
        logic [7:0]  sc;
        logic [7:0]  dc;
        logic [15:0] a_div;
        logic [8:0]  oa_sum;
        sa     = q_item.src[31:24];
        a_div  = aoc_pkg::div255({8'd0, q_item.aprod + aoc_pkg::ROUND_HALF});
        oa_sum = {1'b0, sa} + a_div[8:0];
        s1_oa_next = (oa_sum > {1'b0, aoc_pkg::CH_MAX}) ? aoc_pkg::CH_MAX : oa_sum[7:0];
        for (int c = 0; c < aoc_pkg::NUM_CH; c++)
        begin
            sc = q_item.src[c*aoc_pkg::CH_W +: aoc_pkg::CH_W];
            dc = q_item.dst[c*aoc_pkg::CH_W +: aoc_pkg::CH_W];
            s1_t_next[c] = {16'd0, dc} * {8'd0, q_item.aprod};
            s1_s_next[c] = {8'd0, sc} * {8'd0, sa};
        end
    end

    always_comb
    begin
        logic [15:0] d;
        for (int c = 0; c < aoc_pkg::NUM_CH; c++)
        begin
            d = aoc_pkg::div255(s1_t_reg[c] + {8'd0, aoc_pkg::ROUND_HALF});
            s2_n_next[c] = {1'b0, s1_s_reg[c]} + {1'b0, d} + {10'd0, s1_oa_reg[7:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < aoc_pkg::DIV_STAGES; i++)
            begin
                ln_valid_reg[i] <= 1'b0;
            end
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            used_reg     <= used_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            ln_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < aoc_pkg::DIV_STAGES; i++)
            begin
                ln_valid_reg[i] <= ln_valid_reg[i-1];
            end
            if (ln_valid_reg[LAST])
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bypass_reg <= (q_item.cls != aoc_pkg::CLS_BLEND);
        s1_pix_reg    <= (q_item.cls == aoc_pkg::CLS_DST) ? q_item.dst : q_item.src;
        s1_oa_reg     <= s1_oa_next;
        for (int c = 0; c < aoc_pkg::NUM_CH; c++)
        begin
            s1_t_reg[c] <= s1_t_next[c];
            s1_s_reg[c] <= s1_s_next[c];
            s2_n_reg[c] <= s2_n_next[c];
        end
        s2_bypass_reg <= s1_bypass_reg;
        s2_pix_reg    <= s1_pix_reg;
        s2_oa_reg     <= s1_oa_reg;
        ln_bypass_reg[0] <= s2_bypass_reg;
        ln_pix_reg[0]    <= s2_pix_reg;
        ln_oa_reg[0]     <= s2_oa_reg;
        for (int i = 1; i < aoc_pkg::DIV_STAGES; i++)
        begin
            ln_bypass_reg[i] <= ln_bypass_reg[i-1];
            ln_pix_reg[i]    <= ln_pix_reg[i-1];
            ln_oa_reg[i]     <= ln_oa_reg[i-1];
        end
        if (ln_valid_reg[LAST])
        begin
            mem_reg[wr_ptr_reg[aoc_pkg::OUT_IDX_W-1:0]] <= result;
        end
    end

    for (genvar c = 0; c < aoc_pkg::NUM_CH; c++)
    begin : g_ch
        aoc_divider u_div
        (
            .clk (clk),
            .n   (s2_n_reg[c]),
            .oa  (s2_oa_reg),
            .q   (quo[c])
        );
    end

    assign result = ln_bypass_reg[LAST] ? ln_pix_reg[LAST]
                                        : {ln_oa_reg[LAST], quo[2], quo[1], quo[0]};

    assign composite_pixel = mem_reg[rd_ptr_reg[aoc_pkg::OUT_IDX_W-1:0]];

endmodule

`default_nettype wire

// File: hdl/argb_alpha_over_composite.sv
// Top level of the ARGB8888 source-over compositor with straight alpha.
// Depends on aoc_pkg, aoc_front, aoc_queue and aoc_back.
//
// Usage: both sides look like a queue. A transfer in happens on a rising
// edge where push is high and full is low; it carries destination_pixel and
// source_pixel. A result waits on composite_pixel while empty is low and
// is taken on a rising edge where pop is high.
// Throughput is one pixel per clock while the receiver keeps popping, set by
// the fully pipelined blend path: a front register, a four-entry work queue,
// two arithmetic stages and an eight-stage divider, one quotient bit per stage,
// per color channel.
// Results come out in the order the pixels went in, including pixels that
// pass through unchanged.
// The back end issues work only while the 16-entry result buffer has room
// for everything in flight, so when the receiver stalls the work queue
// fills and full rises; nothing is dropped.
// Reset clears all queues and pipeline valid bits; the block is ready for
// a transfer in the first cycle after reset is released.
`default_nettype none

module argb_alpha_over_composite
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] destination_pixel,
    input  wire logic [31:0] source_pixel,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      composite_pixel
);

    aoc_pkg::qwr_t  q_wr;
    aoc_pkg::work_t q_item;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    aoc_front u_front
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .destination_pixel (destination_pixel),
        .source_pixel      (source_pixel),
        .q_full            (q_full),
        .q_wr              (q_wr)
    );

    aoc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_item  (q_item)
    );

    aoc_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .composite_pixel (composite_pixel)
    );

endmodule

`default_nettype wire
